@@ sv/rl2i_pkg.sv @@
// Package for the radix literal converter: widths, radix codes, character codes and digit decode.
package rl2i_pkg;

    localparam int VALUE_BITS = 32;
    localparam int ACC_W      = VALUE_BITS - 1;
    localparam int OUT_W      = 31;
    localparam int PROD_W     = ACC_W + 4;

    typedef enum logic [1:0] {
        RADIX_AUTO = 2'd0,
        RADIX_BIN  = 2'd1,
        RADIX_DEC  = 2'd2,
        RADIX_HEX  = 2'd3
    } radix_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    typedef struct packed {
        logic [OUT_W-1:0] literal_value;
        logic             is_symbol;
        logic             bad_character;
        logic [7:0]       first_bad_code;
        logic             too_large;
    } result_t;

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Base code RADIX_AUTO never stays active after a first word, but reads as decimal.
    function automatic digit_t digit_decode(input logic [7:0] c, input radix_t base);
        digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (base == RADIX_BIN) begin
            if (c == CH_ZERO || c == CH_ONE) begin
                d.valid = 1'b1;
                d.value = {3'd0, c[0]};
            end
        end else if (is_dec_digit(c)) begin
            d.valid = 1'b1;
            d.value = c[3:0];
        end else if (base == RADIX_HEX) begin
            if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LOW_A && c <= CH_LOW_F)) begin
                d.valid = 1'b1;
                d.value = c[3:0] - 4'd1 + HEX_TEN;
            end
        end
        return d;
    endfunction

endpackage

@@ sv/rl2i_if.sv @@
// Valid/ready channel interfaces for character words in and literal words out.
interface rl2i_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first_char;
    logic       last_char;
    logic [1:0] radix_mode;

    modport source (output valid, char_code, first_char, last_char, radix_mode, input ready);
    modport sink   (input valid, char_code, first_char, last_char, radix_mode, output ready);
endinterface

interface rl2i_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] literal_value;
    logic        is_symbol;
    logic        bad_character;
    logic [7:0]  first_bad_code;
    logic        too_large;

    modport source (output valid, literal_value, is_symbol, bad_character, first_bad_code,
                    too_large, input ready);
    modport sink   (input valid, literal_value, is_symbol, bad_character, first_bad_code,
                    too_large, output ready);
endinterface

@@ sv/rl2i_core.sv @@
// Token state and the per-character accumulate step.
module rl2i_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       char_code,
    input  logic             first_char,
    input  logic [1:0]       radix_mode,
    output rl2i_pkg::result_t result
);
    import rl2i_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    radix_t           base_reg, base_next;
    logic             sym_reg, sym_next;
    logic             bad_reg, bad_next;
    logic [7:0]       code_reg, code_next;
    logic             ovf_reg, ovf_next;

    logic [ACC_W-1:0]        acc_start;
    logic [PROD_W-1:0]       acc_wide;
    logic [PROD_W-1:0]       prod;
    logic [ACC_W+OUT_W-1:0]  out_ext;
    digit_t                  dig;

    always_comb
    begin
        acc_start = acc_reg;
        base_next = base_reg;
        sym_next  = sym_reg;
        bad_next  = bad_reg;
        code_next = code_reg;
        ovf_next  = ovf_reg;
        if (first_char)
        begin
            acc_start = '0;
            bad_next  = 1'b0;
            code_next = 8'd0;
            ovf_next  = 1'b0;
            if (radix_t'(radix_mode) == RADIX_AUTO)
            begin
                base_next = RADIX_DEC;
                sym_next  = !is_dec_digit(char_code);
            end
            else
            begin
                base_next = radix_t'(radix_mode);
                sym_next  = 1'b0;
            end
        end

        dig      = digit_decode(char_code, base_next);
        acc_wide = {4'd0, acc_start};
        unique case (base_next)
            RADIX_BIN: prod = acc_wide << 1;
            RADIX_HEX: prod = acc_wide << 4;
            default:   prod = (acc_wide << 3) + (acc_wide << 1);
        endcase
        prod = prod + {{(PROD_W-4){1'b0}}, dig.value};

        acc_next = acc_start;
        if (!sym_next)
        begin
            acc_next = prod[ACC_W-1:0];
            // Anything above the accumulator width means the signed maximum was passed.
            if (|prod[PROD_W-1:ACC_W])
                ovf_next = 1'b1;
            if (!dig.valid)
            begin
                if (!bad_next)
                    code_next = char_code;
                bad_next = 1'b1;
            end
        end

        out_ext = {{OUT_W{1'b0}}, acc_next};
        if (sym_next)
        begin
            result = '0;
            result.is_symbol = 1'b1;
        end
        else
        begin
            result.literal_value  = out_ext[OUT_W-1:0];
            result.is_symbol      = 1'b0;
            result.bad_character  = bad_next;
            result.first_bad_code = code_next;
            result.too_large      = ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            base_reg <= RADIX_AUTO;
            sym_reg  <= 1'b0;
            bad_reg  <= 1'b0;
            code_reg <= 8'd0;
            ovf_reg  <= 1'b0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            base_reg <= base_next;
            sym_reg  <= sym_next;
            bad_reg  <= bad_next;
            code_reg <= code_next;
            ovf_reg  <= ovf_next;
        end
    end

    // A symbol token leaves the accumulator alone.
    a_symbol_holds_acc: assert property (@(posedge clk) disable iff (!rst_n)
        step && sym_next && !first_char |=> acc_reg == $past(acc_reg))
        else $error("accumulator moved inside a symbol token");

    a_bad_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        !bad_reg |-> code_reg == 8'd0)
        else $error("bad code kept without bad flag");

    a_first_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        step && first_char && sym_next |=> !ovf_reg && !bad_reg)
        else $error("symbol token kept stale flags");

endmodule

@@ sv/radix_literal_to_integer.sv @@
// Top level: input register, token converter and result register.
//
//  channel  | modport | word
//  ---------+---------+-------------------------------------------------------------
//  in_ch    | sink    | char_code, first_char, last_char, radix_mode
//  out_ch   | source  | literal_value, is_symbol, bad_character, first_bad_code, too_large
//
// One character word is taken per cycle unless a last character waits on a stalled output.
// Each word waits in the input register; as a last one leaves, its result is registered
// in the output register. The accumulate step (shift-add by the base) is combinational.
// Reset clears the token state to an empty decimal token and empties both registers.
// A stalled result holds the input register only when that register holds a last character.
module radix_literal_to_integer (
    input  logic        clk,
    input  logic        rst_n,
    rl2i_in_if.sink     in_ch,
    rl2i_out_if.source  out_ch
);
    import rl2i_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;
    logic [1:0] s1_mode_reg;

    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       s1_advance;
    logic       in_take;

    // A character without a result can always move on; a last one needs a free output.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_take = in_ch.valid && in_ch.ready;

    rl2i_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_advance),
        .char_code  (s1_char_reg),
        .first_char (s1_first_reg),
        .radix_mode (s1_mode_reg),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg  <= in_ch.char_code;
            s1_first_reg <= in_ch.first_char;
            s1_last_reg  <= in_ch.last_char;
            s1_mode_reg  <= in_ch.radix_mode;
        end
        if (s1_advance && s1_last_reg)
            out_reg <= core_result;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.literal_value  = out_reg.literal_value;
    assign out_ch.is_symbol      = out_reg.is_symbol;
    assign out_ch.bad_character  = out_reg.bad_character;
    assign out_ch.first_bad_code = out_reg.first_bad_code;
    assign out_ch.too_large      = out_reg.too_large;

    a_symbol_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.is_symbol |->
            out_reg.literal_value == '0 && !out_reg.bad_character && !out_reg.too_large)
        else $error("symbol result carries value or flags");

    a_code_needs_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.bad_character |-> out_reg.first_bad_code == 8'd0)
        else $error("bad code without bad flag");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_last_reg |=> out_valid_reg)
        else $error("last character produced no result");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && s1_last_reg && out_valid_reg)
        else $error("input stalled without a waiting result");

endmodule

@@ tb/literal_result_checker.sv @@
// Checker that predicts each literal word from the character words and compares it with the block.
module literal_result_checker
    import rl2i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rl2i_in_if   in_ch,
    rl2i_out_if  out_ch,
    output int   mismatches,
    output int   outstanding
);

    logic [ACC_W-1:0] tally;
    radix_t           base_sel;
    logic             symbol_tok;
    logic             bad_seen;
    logic [7:0]       first_bad;
    logic             too_big;
    result_t          literal_q[$];

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    // Folds one character word into the token state and queues a literal on a last character.
    task automatic fold_character(input logic [7:0] c, input logic first, input logic last,
                                  input radix_t mode);
        int unsigned mult;
        logic        ok;
        logic [3:0]  dval;
        logic [63:0] scaled;
        result_t     lit;
        if (first) begin
            tally      = '0;
            symbol_tok = 1'b0;
            bad_seen   = 1'b0;
            first_bad  = 8'd0;
            too_big    = 1'b0;
            if (mode == RADIX_AUTO) begin
                base_sel   = RADIX_DEC;
                symbol_tok = !(c >= CH_ZERO && c <= CH_NINE);
            end else begin
                base_sel = mode;
            end
        end
        if (!symbol_tok) begin
            // A base that was never resolved still counts in decimal.
            mult = (base_sel == RADIX_BIN) ? 2 : (base_sel == RADIX_HEX) ? 16 : 10;
            ok   = 1'b0;
            dval = 4'd0;
            if (base_sel == RADIX_BIN) begin
                ok   = (c == CH_ZERO) || (c == CH_ONE);
                dval = {3'd0, c == CH_ONE};
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                ok   = 1'b1;
                dval = c[3:0];
            end else if (base_sel == RADIX_HEX && ((c >= CH_UP_A && c <= CH_UP_F) ||
                                                   (c >= CH_LOW_A && c <= CH_LOW_F))) begin
                ok   = 1'b1;
                dval = c[3:0] + 4'd9;
            end
            // An invalid character still scales the value but adds nothing.
            scaled = 64'(tally) * 64'(mult) + 64'(dval);
            if (scaled[63:ACC_W] != '0)
                too_big = 1'b1;
            tally = scaled[ACC_W-1:0];
            if (!ok) begin
                if (!bad_seen)
                    first_bad = c;
                bad_seen = 1'b1;
            end
        end
        if (last) begin
            lit.is_symbol = symbol_tok;
            if (symbol_tok) begin
                lit.literal_value  = '0;
                lit.bad_character  = 1'b0;
                lit.first_bad_code = 8'd0;
                lit.too_large      = 1'b0;
            end else begin
                lit.literal_value  = tally[OUT_W-1:0];
                lit.bad_character  = bad_seen;
                lit.first_bad_code = first_bad;
                lit.too_large      = too_big;
            end
            literal_q.push_back(lit);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            tally      = '0;
            base_sel   = RADIX_AUTO;
            symbol_tok = 1'b0;
            bad_seen   = 1'b0;
            first_bad  = 8'd0;
            too_big    = 1'b0;
            literal_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (literal_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: literal word expected none, got %h %b %b %h %b", $time,
                             out_ch.literal_value, out_ch.is_symbol, out_ch.bad_character,
                             out_ch.first_bad_code, out_ch.too_large);
                end else begin
                    want = literal_q.pop_front();
                    check_field("literal_value", 64'(want.literal_value),
                                64'(out_ch.literal_value));
                    check_field("is_symbol", 64'(want.is_symbol), 64'(out_ch.is_symbol));
                    check_field("bad_character", 64'(want.bad_character),
                                64'(out_ch.bad_character));
                    check_field("first_bad_code", 64'(want.first_bad_code),
                                64'(out_ch.first_bad_code));
                    check_field("too_large", 64'(want.too_large), 64'(out_ch.too_large));
                end
            end
            if (in_ch.valid && in_ch.ready)
                fold_character(in_ch.char_code, in_ch.first_char, in_ch.last_char,
                               radix_t'(in_ch.radix_mode));
        end
        outstanding = literal_q.size();
    end

endmodule

@@ tb/radix_literal_to_integer_test.sv @@
// Testbench top: clock, reset, character stimulus, result stalls and the final verdict.
module radix_literal_to_integer_test;
    import rl2i_pkg::*;

    localparam int WORD_TARGET = 400;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle;
    int   recv_stall;
    int   failures;
    int   outstanding;
    int   sent;

    rl2i_in_if  in_ch();
    rl2i_out_if out_ch();

    radix_literal_to_integer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    literal_result_checker i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (failures),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall);

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // Offers one character word, after random idle cycles, and holds it until it is taken.
    task automatic send_char(input logic [7:0] c, input logic first, input logic last,
                             input radix_t mode);
        logic took;
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.char_code  <= c;
        in_ch.first_char <= first;
        in_ch.last_char  <= last;
        in_ch.radix_mode <= mode;
        do begin
            @(negedge clk);
            took = in_ch.ready;
            @(posedge clk);
        end while (!took);
        sent++;
    endtask

    task automatic send_text(input string s, input radix_t mode);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], k == 0, k == s.len() - 1, mode);
    endtask

    function automatic logic [7:0] pick_digit(input radix_t mode);
        unique case (mode)
            RADIX_BIN: return CH_ZERO + 8'($urandom_range(1));
            RADIX_HEX:
                unique case ($urandom_range(2))
                    0:       return CH_ZERO + 8'($urandom_range(9));
                    1:       return CH_UP_A + 8'($urandom_range(5));
                    default: return CH_LOW_A + 8'($urandom_range(5));
                endcase
            default:   return CH_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    // Mostly valid digits; now and then a stray byte, a long run that may overflow, or no end.
    task automatic send_token();
        radix_t     mode;
        int         len;
        logic       open_ended;
        logic [7:0] c;
        mode       = radix_t'($urandom_range(3));
        len        = ($urandom_range(9) == 0) ? $urandom_range(13, 34) : $urandom_range(1, 12);
        open_ended = ($urandom_range(9) == 0);
        for (int k = 0; k < len; k++) begin
            c = ($urandom_range(11) == 0) ? 8'($urandom_range(255)) : pick_digit(mode);
            if (k == 0 && mode == RADIX_AUTO && $urandom_range(4) == 0)
                c = 8'($urandom_range(255));
            // The mode only matters on the first word, so the rest carry random modes.
            send_char(c, k == 0, (k == len - 1) && !open_ended,
                      (k == 0) ? mode : radix_t'($urandom_range(3)));
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.char_code  = 8'd0;
        in_ch.first_char = 1'b0;
        in_ch.last_char  = 1'b0;
        in_ch.radix_mode = RADIX_AUTO;
        send_idle        = 21;
        recv_stall       = 51;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Characters before any first word accumulate as decimal.
        send_char("4", 1'b0, 1'b0, RADIX_AUTO);
        send_char("2", 1'b0, 1'b1, RADIX_AUTO);
        send_text("9", RADIX_AUTO);
        send_text("xy", RADIX_AUTO);
        send_text("10Z1", RADIX_BIN);
        send_char(8'h00, 1'b0, 1'b1, RADIX_BIN);
        send_char(8'hFF, 1'b1, 1'b0, RADIX_DEC);
        send_char("9", 1'b0, 1'b1, RADIX_DEC);
        send_text("7fFFffFF", RADIX_HEX);
        // A word after the last one keeps extending the old token, here past the maximum.
        send_char("0", 1'b0, 1'b1, RADIX_AUTO);
        send_text("0ag", RADIX_HEX);

        while (sent < WORD_TARGET) begin
            if (sent >= WORD_TARGET * 2 / 3) begin
                send_idle  = 0;
                recv_stall = 0;
            end else if (sent >= WORD_TARGET / 3) begin
                send_idle  = 51;
                recv_stall = 21;
            end
            if ($urandom_range(11) == 0)
                send_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                          radix_t'($urandom_range(3)));
            else
                send_token();
        end
        in_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
